// ===== src/dht11_receiver_threshold_control_defines.svh =====
// ----------------------------------------------------------------------------
// DHT11 receiver assertion macros
// Shared concurrent assertion helpers for the sensor receiver block.
// ----------------------------------------------------------------------------
`ifndef DHT11_RECEIVER_THRESHOLD_CONTROL_DEFINES_SVH
`define DHT11_RECEIVER_THRESHOLD_CONTROL_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define DHTRC_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// Next-cycle implication, disabled while in reset.
`define DHTRC_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`else

`define DHTRC_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS, MSG)
`define DHTRC_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG)

`endif

`endif

// ===== src/dhtrc_pkg.sv =====
// ----------------------------------------------------------------------------
// DHT11 receiver package
// Payload types, configuration types and fixed constants.
// ----------------------------------------------------------------------------
package dhtrc_pkg;

	localparam int FRAME_BITS = 40;
	localparam int BIT_CNT_W  = 6;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP_THR   = 3'd0;
	localparam logic [2:0] REG_HUMID_THR  = 3'd1;
	localparam logic [2:0] REG_WATER_THR  = 3'd2;
	localparam logic [2:0] REG_TDS_THR    = 3'd3;
	localparam logic [2:0] REG_START_LOW  = 3'd4;
	localparam logic [2:0] REG_SAMPLE_DLY = 3'd5;

	typedef struct packed {
		logic       line_level;
		logic       start_req;
		logic [9:0] water_level;
		logic [9:0] tds_level;
	} tick_t;

	typedef struct packed {
		logic       drive_low;
		logic       fan_on;
		logic       pump_water_on;
		logic       pump_nutrient_on;
		logic       humidifier_on;
		logic       frame_done;
		logic       checksum_error;
		logic [7:0] humidity_out;
		logic [7:0] temperature_out;
		logic       busy_res;
	} result_t;

	typedef struct packed {
		logic [7:0]  temp_limit;
		logic [7:0]  humidity_limit;
		logic [9:0]  water_threshold;
		logic [9:0]  tds_limit;
		logic [15:0] start_low_ticks;
		logic [7:0]  sample_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic humid;
		logic pump_n;
		logic pump_w;
		logic fan;
	} flags_t;

	typedef struct packed {
		logic       good;
		flags_t     flags;
		logic [7:0] humidity;
		logic [7:0] temperature;
	} eval_t;

endpackage

// ===== src/dhtrc_if.sv =====
// ----------------------------------------------------------------------------
// DHT11 receiver channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface dhtrc_tick_if;
	logic            valid;
	logic            ready;
	dhtrc_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dhtrc_result_if;
	logic              valid;
	logic              ready;
	dhtrc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dhtrc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== src/dhtrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// DHT11 receiver register file
// Threshold and timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module dhtrc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	dhtrc_cfg_if.sink     cfg,
	output dhtrc_pkg::cfg_t regs
);

	dhtrc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.temp_limit         <= 8'd25;
			regs_q.humidity_limit     <= 8'd50;
			regs_q.water_threshold    <= 10'd500;
			regs_q.tds_limit          <= 10'd200;
			regs_q.start_low_ticks    <= 16'd20000;
			regs_q.sample_delay_ticks <= 8'd30;
		end else if (cfg.valid) begin
			case (cfg.index)
				dhtrc_pkg::REG_TEMP_THR:   regs_q.temp_limit         <= cfg.wdata[7:0];
				dhtrc_pkg::REG_HUMID_THR:  regs_q.humidity_limit     <= cfg.wdata[7:0];
				dhtrc_pkg::REG_WATER_THR:  regs_q.water_threshold    <= cfg.wdata[9:0];
				dhtrc_pkg::REG_TDS_THR:    regs_q.tds_limit          <= cfg.wdata[9:0];
				dhtrc_pkg::REG_START_LOW:  regs_q.start_low_ticks    <= cfg.wdata;
				dhtrc_pkg::REG_SAMPLE_DLY: regs_q.sample_delay_ticks <= cfg.wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/dhtrc_frame_eval.sv =====
// ----------------------------------------------------------------------------
// DHT11 frame evaluation
// Checksum test and threshold comparison for a completed 40-bit frame.
// ----------------------------------------------------------------------------
module dhtrc_frame_eval (
	input  logic [dhtrc_pkg::FRAME_BITS-1:0] frame,
	input  dhtrc_pkg::cfg_t                  regs,
	input  logic [9:0]                       held_water,
	input  logic [9:0]                       held_tds,
	output dhtrc_pkg::eval_t                 eval
);

	logic [7:0] hum_int, hum_dec, tmp_int, tmp_dec, ck;
	logic [7:0] sum;

	assign hum_int = frame[39:32];
	assign hum_dec = frame[31:24];
	assign tmp_int = frame[23:16];
	assign tmp_dec = frame[15:8];
	assign ck      = frame[7:0];

	// modulo-256 sum of the four data bytes
	assign sum = hum_int + hum_dec + tmp_int + tmp_dec;

	always_comb begin
		eval.good         = (sum == ck);
		eval.humidity     = hum_int;
		eval.temperature  = tmp_int;
		eval.flags.fan    = (tmp_int > regs.temp_limit);
		eval.flags.pump_w = (held_water < regs.water_threshold);
		eval.flags.pump_n = (held_tds > regs.tds_limit);
		eval.flags.humid  = (hum_int < regs.humidity_limit);
	end

endmodule

// ===== src/dht11_receiver_threshold_control.sv =====
// ----------------------------------------------------------------------------
// DHT11 receiver with threshold control
// Single-wire humidity/temperature sensor receiver driving four actuator flags.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick of the sensor line; every accepted
// tick produces exactly one result transaction in the cycle after, showing the
// state after that tick. Ticks are taken one per clock: the whole tick update
// (phase, counters, shift register, checksum and threshold compare) is a
// single registered pass, so the only thing that holds ticks back is the
// result register still waiting for its transaction to be taken. A start
// strobe seen while idle latches the two ADC readings and pulls the line low
// for start_low_ticks ticks (the start tick counts as the first). The block
// then watches for the sensor answer (low, high, low) and receives 40 bits,
// each sampled sample_delay_ticks ticks after its rising edge. Zero in either
// timing register behaves as one. There are no timeouts: a silent sensor
// leaves the block busy. Registers may be written only while idle.
// ----------------------------------------------------------------------------
`include "dht11_receiver_threshold_control_defines.svh"

module dht11_receiver_threshold_control (
	input  logic        clk,
	input  logic        arst_n,
	dhtrc_tick_if.sink     ticks,
	dhtrc_result_if.source results,
	dhtrc_cfg_if.sink      cfg
);

	// Receive phases
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_START_LOW = 3'd1;
	localparam logic [2:0] PH_ANS_LOW   = 3'd2;
	localparam logic [2:0] PH_ANS_HIGH  = 3'd3;
	localparam logic [2:0] PH_ANS_END   = 3'd4;
	localparam logic [2:0] PH_BIT_RISE  = 3'd5;
	localparam logic [2:0] PH_BIT_DELAY = 3'd6;
	localparam logic [2:0] PH_BIT_FALL  = 3'd7;

	localparam logic [dhtrc_pkg::BIT_CNT_W-1:0] LAST_BIT =
		dhtrc_pkg::BIT_CNT_W'(dhtrc_pkg::FRAME_BITS);

	dhtrc_pkg::cfg_t  regs;
	dhtrc_pkg::eval_t eval;

	// tick state
	logic [2:0]                          phase_q, phase_d;
	logic [15:0]                         tick_cnt_q, tick_cnt_d;
	logic [dhtrc_pkg::BIT_CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
	logic [dhtrc_pkg::FRAME_BITS-1:0]    frame_q, frame_d, frame_nxt;
	logic [9:0]                          water_q, water_d, tds_q, tds_d;
	dhtrc_pkg::flags_t                   flags_q, flags_d;
	logic [7:0]                          hum_q, hum_d, temp_q, temp_d;

	// result register
	logic               res_valid_q;
	dhtrc_pkg::result_t res_q;

	logic        acc;
	logic        done_d, err_d;
	logic [15:0] tick_inc;
	logic [15:0] start_eff;
	logic [7:0]  delay_eff;
	logic [dhtrc_pkg::BIT_CNT_W-1:0] bit_inc;
	logic        line;

	dhtrc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Frame as it will look once the current line bit is shifted in
	assign frame_nxt = {frame_q[dhtrc_pkg::FRAME_BITS-2:0], ticks.data.line_level};

	dhtrc_frame_eval u_frame_eval (
		.frame      (frame_nxt),
		.regs       (regs),
		.held_water (water_q),
		.held_tds   (tds_q),
		.eval       (eval)
	);

	// Result register frees itself the same cycle its transaction goes out
	assign ticks.ready = !res_valid_q || results.ready;
	assign acc         = ticks.valid && ticks.ready;

	assign line      = ticks.data.line_level;
	assign tick_inc  = tick_cnt_q + 16'd1;
	assign bit_inc   = bit_cnt_q + 1'b1;
	assign start_eff = (regs.start_low_ticks == 16'd0) ? 16'd1 : regs.start_low_ticks;
	assign delay_eff = (regs.sample_delay_ticks == 8'd0) ? 8'd1 : regs.sample_delay_ticks;

	always_comb begin
		phase_d    = phase_q;
		tick_cnt_d = tick_cnt_q;
		bit_cnt_d  = bit_cnt_q;
		frame_d    = frame_q;
		water_d    = water_q;
		tds_d      = tds_q;
		flags_d    = flags_q;
		hum_d      = hum_q;
		temp_d     = temp_q;
		done_d     = 1'b0;
		err_d      = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (ticks.data.start_req) begin
					water_d    = ticks.data.water_level;
					tds_d      = ticks.data.tds_level;
					tick_cnt_d = '0;
					bit_cnt_d  = '0;
					frame_d    = '0;
					phase_d    = PH_START_LOW;
				end
			end
			PH_START_LOW: begin
				tick_cnt_d = tick_inc;
				// counter wrap also ends the low pulse
				if (tick_inc >= start_eff || tick_inc == 16'd0) begin
					phase_d = PH_ANS_LOW;
				end
			end
			PH_ANS_LOW: begin
				if (!line) phase_d = PH_ANS_HIGH;
			end
			PH_ANS_HIGH: begin
				if (line) phase_d = PH_ANS_END;
			end
			PH_ANS_END: begin
				if (!line) phase_d = PH_BIT_RISE;
			end
			PH_BIT_RISE: begin
				if (line) begin
					tick_cnt_d = '0;
					phase_d    = PH_BIT_DELAY;
				end
			end
			PH_BIT_DELAY: begin
				tick_cnt_d = tick_inc;
				if (tick_inc >= {8'd0, delay_eff}) begin
					frame_d   = frame_nxt;
					bit_cnt_d = bit_inc;
					if (bit_inc >= LAST_BIT) begin
						done_d  = 1'b1;
						phase_d = PH_IDLE;
						if (eval.good) begin
							hum_d   = eval.humidity;
							temp_d  = eval.temperature;
							flags_d = eval.flags;
						end else begin
							err_d = 1'b1;
						end
					end else begin
						phase_d = PH_BIT_FALL;
					end
				end
			end
			PH_BIT_FALL: begin
				if (!line) phase_d = PH_BIT_RISE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_cnt_q <= '0;
			bit_cnt_q  <= '0;
			frame_q    <= '0;
			water_q    <= '0;
			tds_q      <= '0;
			flags_q    <= '0;
			hum_q      <= '0;
			temp_q     <= '0;
		end else if (acc) begin
			phase_q    <= phase_d;
			tick_cnt_q <= tick_cnt_d;
			bit_cnt_q  <= bit_cnt_d;
			frame_q    <= frame_d;
			water_q    <= water_d;
			tds_q      <= tds_d;
			flags_q    <= flags_d;
			hum_q      <= hum_d;
			temp_q     <= temp_d;
		end
	end

	// Result register: valid clears under reset or when taken with no new tick, payload loads on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.drive_low        <= (phase_d == PH_START_LOW);
			res_q.fan_on           <= flags_d.fan;
			res_q.pump_water_on    <= flags_d.pump_w;
			res_q.pump_nutrient_on <= flags_d.pump_n;
			res_q.humidifier_on    <= flags_d.humid;
			res_q.frame_done       <= done_d;
			res_q.checksum_error   <= err_d;
			res_q.humidity_out     <= hum_d;
			res_q.temperature_out  <= temp_d;
			res_q.busy_res         <= (phase_d != PH_IDLE);
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// a checksum error is only ever reported on the frame-completion tick
	`DHTRC_ASSERT_SAME(a_err_needs_done, clk, arst_n, results.valid && results.data.checksum_error, results.data.frame_done, "checksum_error without frame_done")

	// pulling the line low is part of a measurement
	`DHTRC_ASSERT_SAME(a_drive_implies_busy, clk, arst_n, results.valid && results.data.drive_low, results.data.busy_res, "drive_low while not busy")

	// the frame can only complete on the last of the 40 bits
	`DHTRC_ASSERT_SAME(a_done_on_last_bit, clk, arst_n, acc && done_d, bit_cnt_q == LAST_BIT - 1'b1, "frame completed at wrong bit count")

	// actuator flags move only on a good frame
	`DHTRC_ASSERT_NEXT(a_flags_hold, clk, arst_n, !(acc && done_d && !err_d), $stable(flags_q), "actuator flags changed without a good frame")

endmodule
